### sv/smle_pkg.sv
// Shared types and constants for the sorted multiset list engine.
package smle_pkg;

    localparam int VALUE_W  = 32;
    localparam int OPCODE_W = 3;
    localparam int STATUS_W = 3;

    localparam logic [OPCODE_W-1:0] OP_INSERT    = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_REMOVE    = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_LIST_ASC  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_LIST_DESC = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_EVEN_ASC  = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_EVEN_DESC = 3'd5;

    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ITEM     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_RD,
        S_INS_CMP,
        S_RM_RD,
        S_RM_CMP,
        S_SH_RD,
        S_SH_WR,
        S_LS_RD,
        S_LS_CMP,
        S_LS_END
    } state_t;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_IDX_M1,
        RD_IDX_P1
    } rd_sel_t;

    typedef enum logic [1:0] {
        OUT_VALUE,
        OUT_PEND,
        OUT_ZERO
    } out_src_t;

    typedef struct packed {
        logic                load;
        logic                idx_clr;
        logic                idx_from_cnt;
        logic                idx_inc;
        logic                idx_dec;
        logic                rd_en;
        rd_sel_t             rd_sel;
        logic                wr_en;
        logic                wr_value;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                pend_load;
        logic                emit;
        out_src_t            emit_src;
        logic [STATUS_W-1:0] emit_status;
        logic                emit_last;
    } cmd_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic                full;
        logic                idx_zero;
        logic                idx_at_end;
        logic                next_in_range;
        logic                key_ge;
        logic                data_eq;
        logic                data_even;
        logic                pend_valid;
    } stat_t;

endpackage

### sv/smle_ctrl.sv
// Controller state machine sequencing insert, remove and list transactions.
module smle_ctrl
    import smle_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy
);

    state_t state_reg;
    state_t state_next;
    logic   desc;
    logic   evens;

    assign desc  = (stat.op == OP_LIST_DESC) || (stat.op == OP_EVEN_DESC);
    assign evens = (stat.op == OP_EVEN_ASC) || (stat.op == OP_EVEN_DESC);
    assign busy  = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.rd_sel      = RD_IDX;
        cmd.emit_src    = OUT_VALUE;
        cmd.emit_status = ST_DONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (stat.op) inside
                    OP_INSERT:
                    begin
                        if (stat.full)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = ST_FULL;
                            cmd.emit_last   = 1'b1;
                            state_next      = S_IDLE;
                        end
                        else
                        begin
                            cmd.idx_from_cnt = 1'b1;
                            state_next       = S_INS_RD;
                        end
                    end
                    OP_REMOVE:
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = S_RM_RD;
                    end
                    OP_LIST_ASC, OP_EVEN_ASC:
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = S_LS_RD;
                    end
                    OP_LIST_DESC, OP_EVEN_DESC:
                    begin
                        cmd.idx_from_cnt = 1'b1;
                        state_next       = S_LS_RD;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            // Walk down from the top, moving entries not below the new value up one slot.
            S_INS_RD:
            begin
                if (stat.idx_zero)
                begin
                    cmd.wr_en     = 1'b1;
                    cmd.wr_value  = 1'b1;
                    cmd.cnt_inc   = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX_M1;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                cmd.wr_en = 1'b1;
                if (stat.key_ge)
                begin
                    cmd.idx_dec = 1'b1;
                    state_next  = S_INS_RD;
                end
                else
                begin
                    cmd.wr_value  = 1'b1;
                    cmd.cnt_inc   = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_RM_RD:
            begin
                if (stat.idx_at_end)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_NOTFOUND;
                    cmd.emit_last   = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_RM_CMP;
                end
            end
            S_RM_CMP:
            begin
                if (stat.data_eq)
                begin
                    state_next = S_SH_RD;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_RM_RD;
                end
            end
            // Close the gap left by the removed entry.
            S_SH_RD:
            begin
                if (stat.next_in_range)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX_P1;
                    state_next = S_SH_WR;
                end
                else
                begin
                    cmd.cnt_dec   = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_SH_WR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = S_SH_RD;
            end
            S_LS_RD:
            begin
                if (desc ? stat.idx_zero : stat.idx_at_end)
                begin
                    state_next = S_LS_END;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = desc ? RD_IDX_M1 : RD_IDX;
                    cmd.idx_dec = desc;
                    cmd.idx_inc = !desc;
                    state_next  = S_LS_CMP;
                end
            end
            // Hold one qualifying entry back so the final one can carry last.
            S_LS_CMP:
            begin
                if (!evens || stat.data_even)
                begin
                    cmd.pend_load   = 1'b1;
                    cmd.emit        = stat.pend_valid;
                    cmd.emit_src    = OUT_PEND;
                    cmd.emit_status = ST_ITEM;
                end
                state_next = S_LS_RD;
            end
            S_LS_END:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_last = 1'b1;
                if (stat.pend_valid)
                begin
                    cmd.emit_src    = OUT_PEND;
                    cmd.emit_status = ST_ITEM;
                end
                else
                begin
                    cmd.emit_src    = OUT_ZERO;
                    cmd.emit_status = ST_EMPTY;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_no_write_while_listing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LS_RD || state_reg == S_LS_CMP || state_reg == S_LS_END)
        |-> !cmd.wr_en)
        else $error("store written during a list transaction");

    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == S_IDLE))
        else $error("transaction loaded while busy");

endmodule

### sv/smle_datapath.sv
// Datapath: value store, index and count registers, pending entry and result register.
module smle_datapath
    import smle_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cmd_t                       cmd,
    input  logic [OPCODE_W-1:0]        opcode,
    input  logic signed [VALUE_W-1:0]  value,
    output stat_t                      stat,
    output logic                       strobe,
    output logic signed [VALUE_W-1:0]  item_value,
    output logic [STATUS_W-1:0]        status,
    output logic                       last
);

    localparam int IW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    logic signed [VALUE_W-1:0] mem [CAPACITY];

    logic [OPCODE_W-1:0]       op_reg;
    logic signed [VALUE_W-1:0] val_reg;
    logic [IW-1:0]             count_reg;
    logic [IW-1:0]             idx_reg;
    logic signed [VALUE_W-1:0] rd_data_reg;
    logic signed [VALUE_W-1:0] pend_reg;
    logic                      pend_valid_reg;
    logic                      strobe_reg;
    logic signed [VALUE_W-1:0] item_value_reg;
    logic [STATUS_W-1:0]       status_reg;
    logic                      last_reg;

    logic [IW-1:0]             idx_m1;
    logic [IW-1:0]             idx_p1;
    logic [AW-1:0]             rd_addr;
    logic signed [VALUE_W-1:0] wr_data;
    logic signed [VALUE_W-1:0] emit_data;

    assign idx_m1  = idx_reg - 1'b1;
    assign idx_p1  = idx_reg + 1'b1;
    assign wr_data = cmd.wr_value ? val_reg : rd_data_reg;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_IDX_M1: rd_addr = idx_m1[AW-1:0];
            RD_IDX_P1: rd_addr = idx_p1[AW-1:0];
            default:   rd_addr = idx_reg[AW-1:0];
        endcase
    end

    always_comb
    begin
        case (cmd.emit_src)
            OUT_PEND: emit_data = pend_reg;
            OUT_ZERO: emit_data = '0;
            default:  emit_data = val_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[idx_reg[AW-1:0]] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            val_reg <= value;
        end
        if (cmd.pend_load)
        begin
            pend_reg <= rd_data_reg;
        end
        if (cmd.emit)
        begin
            item_value_reg <= emit_data;
            status_reg     <= cmd.emit_status;
            last_reg       <= cmd.emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit;
            if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_from_cnt)
            begin
                idx_reg <= count_reg;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_p1;
            end
            else if (cmd.idx_dec)
            begin
                idx_reg <= idx_m1;
            end
            if (cmd.load)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.pend_load)
            begin
                pend_valid_reg <= 1'b1;
            end
        end
    end

    assign stat.op            = op_reg;
    assign stat.full          = (count_reg == IW'(CAPACITY));
    assign stat.idx_zero      = (idx_reg == '0);
    assign stat.idx_at_end    = (idx_reg >= count_reg);
    assign stat.next_in_range = (idx_p1 < count_reg);
    assign stat.key_ge        = (rd_data_reg >= val_reg);
    assign stat.data_eq       = (rd_data_reg == val_reg);
    assign stat.data_even     = !rd_data_reg[0];
    assign stat.pend_valid    = pend_valid_reg;

    assign strobe     = strobe_reg;
    assign item_value = item_value_reg;
    assign status     = status_reg;
    assign last       = last_reg;

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= IW'(CAPACITY))
        else $error("entry count above capacity");

    a_count_change_reports: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (strobe_reg && last_reg && status_reg == ST_DONE))
        else $error("entry count changed without a done result");

    a_count_steps_one: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.cnt_inc && cmd.cnt_dec))
        else $error("count incremented and decremented together");

endmodule

### sv/sorted_multiset_list_engine.sv
// Sorted multiset engine: bounded store of signed 32-bit values kept in ascending order.
// Usage:
//   Present opcode and value with start high; a transaction is taken at a rising edge
//   where start is high and busy is low. busy stays high until the transaction is done.
//   Results appear on item_value, status and last, marked by strobe high for exactly
//   one cycle; the receiver must take every result, there is no back pressure.
//   Insert and remove give one result (done, store full or not found).
//   List commands give one result per listed entry (status item), last on the final
//   one, or a single nothing-to-list result. Opcodes 6 and 7 give no result.
// Sequencing (n = entries stored; the memory read is registered, so each visited entry
// takes a read state followed by a compare or write state):
//   insert: walks down from the top over the entries not below the new value, moving
//           each up one slot, then writes the value; a full store is refused at dispatch.
//   remove: searches up from the bottom and, if found, shifts the later entries down.
//   list:   visits all n entries; results stream out one per visited qualifying entry.
//   Opcodes 6 and 7 hold busy only through the dispatch state.
//   A new transaction is taken in the cycle its predecessor's last result is shown.
// Reset: the store becomes empty at once; no clearing pass is needed.
module sorted_multiset_list_engine
    import smle_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [OPCODE_W-1:0]        opcode,
    input  logic signed [VALUE_W-1:0]  value,
    output logic                       strobe,
    output logic signed [VALUE_W-1:0]  item_value,
    output logic [STATUS_W-1:0]        status,
    output logic                       last
);

    cmd_t  cmd;
    stat_t stat;

    smle_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    smle_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .opcode     (opcode),
        .value      (value),
        .stat       (stat),
        .strobe     (strobe),
        .item_value (item_value),
        .status     (status),
        .last       (last)
    );

endmodule
